[hdl/int8_matmul_zero_point_assert.svh]
// Assertion macros shared by the checker of the int8 matmul block.
// No dependencies; include by bare file name.
`ifndef INT8_MATMUL_ZERO_POINT_ASSERT_SVH
`define INT8_MATMUL_ZERO_POINT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IMZP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("imzp: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define IMZP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("imzp: next-cycle check failed");

`endif

[hdl/imzp_pkg.sv]
// Shared types, widths, register codes and element adjust function
// for the int8 matmul block. No dependencies.
`timescale 1ns / 1ps

package imzp_pkg;

   localparam int ELEM_W      = 8;
   localparam int VAL_W       = 10;
   localparam int PROD_W      = 20;
   localparam int ACC_W       = 32;
   localparam int OFS_W       = 9;
   localparam int DIM_W       = 4;
   localparam int INNER_IDX_W = 6;
   localparam int ROW_W       = 3;
   localparam int COL_W       = 3;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 9;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ROWS_A      = 3'd0,
      CSR_INNER_LEN   = 3'd1,
      CSR_COLS_B      = 3'd2,
      CSR_A_IS_SIGNED = 3'd3,
      CSR_B_IS_SIGNED = 3'd4,
      CSR_A_OFFSET    = 3'd5,
      CSR_B_OFFSET    = 3'd6
   } csr_index_type;

   // Operand handed from cell to cell
   typedef struct packed {
      logic                          valid;
      logic signed [VAL_W-1:0]       a_val;
      logic [INNER_IDX_W-1:0]        idx;
      logic                          first;
      logic                          last;
   } tok_type;

   typedef struct packed {
      logic                          is_signed;
      logic [OFS_W-1:0]              offset;
   } elem_cfg_type;

   typedef struct packed {
      logic                          en;
      logic [COL_W-1:0]              col;
      logic [INNER_IDX_W-1:0]        idx;
      logic [ELEM_W-1:0]             data;
   } bwr_type;

   typedef struct packed {
      logic                          shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic                          done;
   } cell_stat_type;

   // Read a raw byte as int8 or uint8 and subtract the zero point
   function automatic logic signed [VAL_W-1:0] adjust_elem(
      input logic [ELEM_W-1:0] raw,
      input logic              is_signed,
      input logic [OFS_W-1:0]  offset
   );
      logic signed [VAL_W-1:0] v;
      logic signed [VAL_W-1:0] z;
      v = is_signed ? {{(VAL_W-ELEM_W){raw[ELEM_W-1]}}, raw}
                    : {{(VAL_W-ELEM_W){1'b0}}, raw};
      z = {{(VAL_W-OFS_W){offset[OFS_W-1]}}, offset};
      return v - z;
   endfunction

endpackage

[hdl/imzp_channels.sv]
// Valid/ready channel interfaces for the int8 matmul block.
// Depends on imzp_pkg for field widths.
`timescale 1ns / 1ps

interface imzp_req_if;
   logic                              valid;
   logic                              ready;
   logic                              op;
   logic [imzp_pkg::ELEM_W-1:0]       elem_byte;

   modport source(output valid, op, elem_byte, input ready);
   modport sink(input valid, op, elem_byte, output ready);
endinterface

interface imzp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [imzp_pkg::ACC_W-1:0] product_value;
   logic [imzp_pkg::ROW_W-1:0]        out_row;
   logic [imzp_pkg::COL_W-1:0]        out_col;
   logic                              is_last;

   modport source(output valid, product_value, out_row, out_col, is_last, input ready);
   modport sink(input valid, product_value, out_row, out_col, is_last, output ready);
endinterface

[hdl/imzp_cell.sv]
// One column cell of the matmul chain: holds one column of B, multiplies
// the passing A operand and accumulates. Depends on imzp_pkg.
`timescale 1ns / 1ps

module imzp_cell #(
   parameter int MAX_INNER = 8,
   parameter int COL       = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  imzp_pkg::elem_cfg_type              bcfg,
   input  imzp_pkg::bwr_type                   bwr,
   input  imzp_pkg::cell_ctrl_type             ctrl,
   input  imzp_pkg::tok_type                   tok_in,
   output imzp_pkg::tok_type                   tok_out,
   input  logic signed [imzp_pkg::ACC_W-1:0]   res_in,
   output logic signed [imzp_pkg::ACC_W-1:0]   res_out,
   output imzp_pkg::cell_stat_type             stat
);

   localparam int IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

   logic [imzp_pkg::ELEM_W-1:0]         col_mem [MAX_INNER];
   logic [imzp_pkg::ELEM_W-1:0]         b_rd_ff;
   imzp_pkg::tok_type                   tok_ff;
   logic signed [imzp_pkg::VAL_W-1:0]   b_adj;
   logic signed [imzp_pkg::PROD_W-1:0]  prod_ff;
   logic                                v2_ff;
   logic                                first2_ff;
   logic                                last2_ff;
   logic signed [imzp_pkg::ACC_W-1:0]   res_ff;
   logic                                done_ff;

   always_ff @(posedge clock) begin
      if (bwr.en && (bwr.col == imzp_pkg::COL_W'(COL))) begin
         col_mem[bwr.idx[IW-1:0]] <= bwr.data;
      end
      b_rd_ff <= col_mem[tok_in.idx[IW-1:0]];
   end

   assign b_adj = imzp_pkg::adjust_elem(b_rd_ff, bcfg.is_signed, bcfg.offset);

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         v2_ff        <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         tok_ff    <= tok_in;
         v2_ff     <= tok_ff.valid;
         first2_ff <= tok_ff.first;
         last2_ff  <= tok_ff.last;
         prod_ff   <= $signed(tok_ff.a_val) * b_adj;
         done_ff   <= v2_ff && last2_ff;
      end
   end

   // Drain shifts results toward cell zero; otherwise accumulate
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         res_ff <= res_in;
      end else if (v2_ff) begin
         res_ff <= first2_ff ? imzp_pkg::ACC_W'(prod_ff)
                             : res_ff + imzp_pkg::ACC_W'(prod_ff);
      end
   end

   assign tok_out   = tok_ff;
   assign res_out   = res_ff;
   assign stat.done = done_ff;

endmodule

[hdl/int8_matmul_zero_point.sv]
// Top level of the quantized int8 matmul block: load sequencer, A store,
// cell chain and result register. Depends on imzp_pkg, imzp_channels, imzp_cell.
`timescale 1ns / 1ps

// Usage:
//  req channel: one beat per element, op 0 for A and op 1 for B, row-major.
//  Beats are taken one per cycle while loading; A beats beyond M*K are dropped.
//  The beat that completes B starts computation; req ready stays low until the
//  whole M x N result matrix has been handed to the output register.
//  Per row of A: its K elements are issued into the cell chain and pass through
//  it (one hop per cell plus read, multiply and accumulate stages), then N result
//  beats follow, one per cycle while rsp ready is high.
//  rsp channel: one beat per result in row-major order, is_last on the final.
//  A registered output stage holds a stalled beat; the drain waits for it.
//  csr port: write rows_a, inner_len or cols_b only while idle; such a write
//  restarts loading. Offsets and signedness apply when results are computed.
//  Reset: synchronous; dimensions go to 8, offsets and signedness to 0, load
//  counts to 0. The A and B stores are not cleared.

module int8_matmul_zero_point #(
   parameter int MAX_ROWS  = 8,
   parameter int MAX_INNER = 8,
   parameter int MAX_COLS  = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   imzp_req_if.sink                            req_bus,
   imzp_rsp_if.source                          rsp_bus,
   input  logic                                csr_wr_en,
   input  logic [imzp_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [imzp_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
   localparam int B_DEPTH = MAX_INNER * MAX_COLS;
   localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
   localparam int A_CW    = $clog2(A_DEPTH + 1);
   localparam int B_CW    = $clog2(B_DEPTH + 1);
   localparam int M_W     = $clog2(MAX_ROWS + 1);
   localparam int K_W     = $clog2(MAX_INNER + 1);
   localparam int N_W     = $clog2(MAX_COLS + 1);
   localparam int K_IW    = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
   localparam int TIW     = imzp_pkg::INNER_IDX_W;
   localparam int DW      = imzp_pkg::DIM_W;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_RUN,
      ST_WAIT,
      ST_DRAIN
   } state_type;

   state_type                               state_ff;

   logic [DW-1:0]                           rows_a_ff;
   logic [DW-1:0]                           inner_ff;
   logic [DW-1:0]                           cols_ff;
   logic                                    a_signed_ff;
   logic                                    b_signed_ff;
   logic [imzp_pkg::OFS_W-1:0]              a_ofs_ff;
   logic [imzp_pkg::OFS_W-1:0]              b_ofs_ff;

   logic [A_CW-1:0]                         a_cnt_ff;
   logic [B_CW-1:0]                         b_cnt_ff;
   logic [TIW-1:0]                          b_row_ff;
   logic [imzp_pkg::COL_W-1:0]              b_col_ff;

   logic [imzp_pkg::ROW_W-1:0]              r_ff;
   logic [K_IW-1:0]                         i_ff;
   logic [imzp_pkg::COL_W-1:0]              c_ff;
   logic [A_AW-1:0]                         a_addr_ff;

   logic                                    tok_v_ff;
   logic [TIW-1:0]                          tok_idx_ff;
   logic                                    tok_first_ff;
   logic                                    tok_last_ff;

   logic [imzp_pkg::ELEM_W-1:0]             a_mem [A_DEPTH];
   logic [imzp_pkg::ELEM_W-1:0]             a_rd_ff;

   logic                                    rsp_valid_ff;
   logic signed [imzp_pkg::ACC_W-1:0]       rsp_value_ff;
   logic [imzp_pkg::ROW_W-1:0]              rsp_row_ff;
   logic [imzp_pkg::COL_W-1:0]              rsp_col_ff;
   logic                                    rsp_last_ff;

   logic [M_W-1:0]                          m_dim;
   logic [K_W-1:0]                          k_dim;
   logic [N_W-1:0]                          n_dim;
   logic [A_CW-1:0]                         a_total;
   logic [B_CW-1:0]                         b_total;
   logic                                    req_fire;
   logic                                    a_room;
   logic                                    b_room;
   logic                                    a_wr_en;
   logic                                    b_done_now;
   logic                                    b_col_last;
   logic                                    i_last;
   logic                                    r_last;
   logic                                    c_last;
   logic                                    out_free;
   logic                                    chain_done;

   imzp_pkg::elem_cfg_type                  bcfg;
   imzp_pkg::bwr_type                       bwr;
   imzp_pkg::cell_ctrl_type                 ctrl;
   imzp_pkg::tok_type                       tok_chain [MAX_COLS+1];
   logic signed [imzp_pkg::ACC_W-1:0]       res_chain [MAX_COLS+1];
   imzp_pkg::cell_stat_type                 stat_chain [MAX_COLS];

   // Clamp the shape registers into range
   always_comb begin
      if (rows_a_ff == '0) begin
         m_dim = M_W'(1);
      end else if (32'(rows_a_ff) > MAX_ROWS) begin
         m_dim = M_W'(MAX_ROWS);
      end else begin
         m_dim = M_W'(rows_a_ff);
      end
      if (inner_ff == '0) begin
         k_dim = K_W'(1);
      end else if (32'(inner_ff) > MAX_INNER) begin
         k_dim = K_W'(MAX_INNER);
      end else begin
         k_dim = K_W'(inner_ff);
      end
      if (cols_ff == '0) begin
         n_dim = N_W'(1);
      end else if (32'(cols_ff) > MAX_COLS) begin
         n_dim = N_W'(MAX_COLS);
      end else begin
         n_dim = N_W'(cols_ff);
      end
   end

   assign a_total    = A_CW'(A_CW'(m_dim) * A_CW'(k_dim));
   assign b_total    = B_CW'(B_CW'(k_dim) * B_CW'(n_dim));
   assign req_fire   = req_bus.valid && req_bus.ready;
   assign a_room     = a_cnt_ff < a_total;
   assign b_room     = b_cnt_ff < b_total;
   assign a_wr_en    = req_fire && !req_bus.op && a_room;
   assign b_done_now = (b_cnt_ff + 1'b1) == b_total;
   assign b_col_last = (32'(b_col_ff) + 1) == 32'(n_dim);
   assign i_last     = (32'(i_ff) + 1) == 32'(k_dim);
   assign r_last     = (32'(r_ff) + 1) == 32'(m_dim);
   assign c_last     = (32'(c_ff) + 1) == 32'(n_dim);
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign chain_done = stat_chain[MAX_COLS-1].done;

   assign req_bus.ready = (state_ff == ST_LOAD);

   assign bwr.en   = req_fire && req_bus.op && b_room;
   assign bwr.col  = b_col_ff;
   assign bwr.idx  = b_row_ff;
   assign bwr.data = req_bus.elem_byte;

   assign bcfg.is_signed = b_signed_ff;
   assign bcfg.offset    = b_ofs_ff;

   assign ctrl.shift = (state_ff == ST_DRAIN) && out_free;

   always_ff @(posedge clock) begin
      if (a_wr_en) begin
         a_mem[a_cnt_ff[A_AW-1:0]] <= req_bus.elem_byte;
      end
      a_rd_ff <= a_mem[a_addr_ff];
   end

   always_comb begin
      tok_chain[0].valid = tok_v_ff;
      tok_chain[0].a_val = imzp_pkg::adjust_elem(a_rd_ff, a_signed_ff, a_ofs_ff);
      tok_chain[0].idx   = tok_idx_ff;
      tok_chain[0].first = tok_first_ff;
      tok_chain[0].last  = tok_last_ff;
   end

   assign res_chain[MAX_COLS] = '0;

   for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
      imzp_cell #(
         .MAX_INNER (MAX_INNER),
         .COL       (c)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .bcfg    (bcfg),
         .bwr     (bwr),
         .ctrl    (ctrl),
         .tok_in  (tok_chain[c]),
         .tok_out (tok_chain[c+1]),
         .res_in  (res_chain[c+1]),
         .res_out (res_chain[c]),
         .stat    (stat_chain[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rows_a_ff    <= DW'(8);
         inner_ff     <= DW'(8);
         cols_ff      <= DW'(8);
         a_signed_ff  <= 1'b0;
         b_signed_ff  <= 1'b0;
         a_ofs_ff     <= '0;
         b_ofs_ff     <= '0;
         a_cnt_ff     <= '0;
         b_cnt_ff     <= '0;
         b_row_ff     <= '0;
         b_col_ff     <= '0;
         r_ff         <= '0;
         i_ff         <= '0;
         c_ff         <= '0;
         a_addr_ff    <= '0;
         tok_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tok_v_ff <= 1'b0;
         // Drop a taken beat unless the drain refills the stage this cycle
         if (rsp_valid_ff && rsp_bus.ready && !ctrl.shift) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_LOAD: begin
               if (req_fire) begin
                  if (!req_bus.op) begin
                     if (a_room) begin
                        a_cnt_ff <= a_cnt_ff + 1'b1;
                     end
                  end else if (b_room) begin
                     if (b_done_now) begin
                        a_cnt_ff  <= '0;
                        b_cnt_ff  <= '0;
                        b_row_ff  <= '0;
                        b_col_ff  <= '0;
                        r_ff      <= '0;
                        i_ff      <= '0;
                        a_addr_ff <= '0;
                        state_ff  <= ST_RUN;
                     end else begin
                        b_cnt_ff <= b_cnt_ff + 1'b1;
                        if (b_col_last) begin
                           b_col_ff <= '0;
                           b_row_ff <= b_row_ff + 1'b1;
                        end else begin
                           b_col_ff <= b_col_ff + 1'b1;
                        end
                     end
                  end
               end
            end
            ST_RUN: begin
               // Issue one A element of the current row per cycle
               tok_v_ff     <= 1'b1;
               tok_idx_ff   <= TIW'(i_ff);
               tok_first_ff <= (i_ff == '0);
               tok_last_ff  <= i_last;
               a_addr_ff    <= a_addr_ff + 1'b1;
               if (i_last) begin
                  i_ff     <= '0;
                  state_ff <= ST_WAIT;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            ST_WAIT: begin
               if (chain_done) begin
                  c_ff     <= '0;
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= res_chain[0];
                  rsp_row_ff   <= r_ff;
                  rsp_col_ff   <= c_ff;
                  rsp_last_ff  <= r_last && c_last;
                  if (c_last) begin
                     if (r_last) begin
                        state_ff <= ST_LOAD;
                     end else begin
                        r_ff     <= r_ff + 1'b1;
                        state_ff <= ST_RUN;
                     end
                  end else begin
                     c_ff <= c_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase

         if (csr_wr_en) begin
            unique case (imzp_pkg::csr_index_type'(csr_addr))
               imzp_pkg::CSR_ROWS_A: begin
                  rows_a_ff <= csr_wr_data[DW-1:0];
                  a_cnt_ff  <= '0;
                  b_cnt_ff  <= '0;
                  b_row_ff  <= '0;
                  b_col_ff  <= '0;
               end
               imzp_pkg::CSR_INNER_LEN: begin
                  inner_ff <= csr_wr_data[DW-1:0];
                  a_cnt_ff <= '0;
                  b_cnt_ff <= '0;
                  b_row_ff <= '0;
                  b_col_ff <= '0;
               end
               imzp_pkg::CSR_COLS_B: begin
                  cols_ff  <= csr_wr_data[DW-1:0];
                  a_cnt_ff <= '0;
                  b_cnt_ff <= '0;
                  b_row_ff <= '0;
                  b_col_ff <= '0;
               end
               imzp_pkg::CSR_A_IS_SIGNED: begin
                  a_signed_ff <= csr_wr_data[0];
               end
               imzp_pkg::CSR_B_IS_SIGNED: begin
                  b_signed_ff <= csr_wr_data[0];
               end
               imzp_pkg::CSR_A_OFFSET: begin
                  a_ofs_ff <= csr_wr_data;
               end
               imzp_pkg::CSR_B_OFFSET: begin
                  b_ofs_ff <= csr_wr_data;
               end
               default: begin
                  // drop writes to unused indexes
               end
            endcase
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.product_value = rsp_value_ff;
   assign rsp_bus.out_row       = rsp_row_ff;
   assign rsp_bus.out_col       = rsp_col_ff;
   assign rsp_bus.is_last       = rsp_last_ff;

endmodule

[hdl/imzp_checker.sv]
// Port-level checker for the int8 matmul block, bound to the top level.
// Depends on int8_matmul_zero_point_assert.svh and imzp_pkg.
`timescale 1ns / 1ps
`include "int8_matmul_zero_point_assert.svh"

module imzp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_op,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [imzp_pkg::ACC_W-1:0]   rsp_value,
   input logic [imzp_pkg::ROW_W-1:0]          rsp_row,
   input logic [imzp_pkg::COL_W-1:0]          rsp_col,
   input logic                                rsp_last
);

   // A stalled result beat holds
   `IMZP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_row) && $stable(rsp_col) && $stable(rsp_last))

   // Reset empties the output stage
   `IMZP_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid)

   // No input is taken while a matrix is still draining
   `IMZP_ASSERT_SAME(a_busy_drain, clock, reset, rsp_valid && !rsp_last, !req_ready)

   // An A beat never starts computation
   `IMZP_ASSERT_NEXT(a_a_beat_idle, clock, reset, req_valid && req_ready && !req_op, req_ready)

endmodule

bind int8_matmul_zero_point imzp_checker u_imzp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_op    (req_bus.op),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_value (rsp_bus.product_value),
   .rsp_row   (rsp_bus.out_row),
   .rsp_col   (rsp_bus.out_col),
   .rsp_last  (rsp_bus.is_last)
);

[verif/int8_matmul_zero_point_tb.sv]
`timescale 1ns / 1ps
// Testbench for int8_matmul_zero_point: streams A and B element beats with register writes
// between and during matrices, predicts every M x N result and checks the result beats in order.
// Depends on imzp_pkg, imzp_channels and the block's RTL.

module int8_matmul_zero_point_tb;

   localparam int DIM_MAX        = 8;
   localparam int STORE_DEPTH    = 64;
   localparam int BEAT_TARGET    = 270;
   localparam int SETTLE_CYCLES  = 32;
   localparam int END_CYCLES     = 64;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int ERROR_PRINTS   = 40;

   localparam logic OP_LOAD_A = 1'b0;
   localparam logic OP_LOAD_B = 1'b1;

   typedef enum logic [1:0] {WORK_BEAT, WORK_CSR, WORK_PAUSE} work_kind_type;

   typedef struct {
      work_kind_type                       kind;
      logic                                op;
      logic [imzp_pkg::ELEM_W-1:0]         elem;
      imzp_pkg::csr_index_type             csr_idx;
      logic [imzp_pkg::CSR_DATA_W-1:0]     csr_data;
   } work_type;

   typedef struct packed {
      logic [imzp_pkg::ACC_W-1:0] value;
      logic [imzp_pkg::ROW_W-1:0] row;
      logic [imzp_pkg::COL_W-1:0] col;
      logic                       last;
   } product_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_wr_en   = 1'b0;
   logic [imzp_pkg::CSR_ADDR_W-1:0] csr_addr    = '0;
   logic [imzp_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;

   imzp_req_if req_bus();
   imzp_rsp_if rsp_bus();

   int8_matmul_zero_point dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   int unsigned err_count   = 0;
   int unsigned cycle_count = 0;
   int unsigned idle_cycles = 0;

   // ---------------- result predictor ----------------
   logic [imzp_pkg::ELEM_W-1:0] a_bytes [STORE_DEPTH];
   logic [imzp_pkg::ELEM_W-1:0] b_bytes [STORE_DEPTH];
   int unsigned       a_fill = 0;
   int unsigned       b_fill = 0;
   logic [3:0]        rows_cfg  = 4'd8;
   logic [3:0]        inner_cfg = 4'd8;
   logic [3:0]        cols_cfg  = 4'd8;
   logic              a_signed_cfg = 1'b0;
   logic              b_signed_cfg = 1'b0;
   logic [imzp_pkg::OFS_W-1:0] a_zero_cfg = '0;
   logic [imzp_pkg::OFS_W-1:0] b_zero_cfg = '0;
   product_type       expected_products[$];

   function automatic int unsigned dim_in_use(logic [3:0] raw, int unsigned hi);
      if (raw == 4'd0) return 1;
      if (raw > hi) return hi;
      return raw;
   endfunction

   function automatic int elem_value(logic [imzp_pkg::ELEM_W-1:0] raw, logic sgn,
                                     logic [imzp_pkg::OFS_W-1:0] zp);
      int v;
      int z;
      v = raw;
      if (sgn && raw[imzp_pkg::ELEM_W-1]) v = v - 256;
      z = zp;
      if (zp[imzp_pkg::OFS_W-1]) z = z - 512;
      return v - z;
   endfunction

   task automatic multiply_matrices();
      int unsigned m;
      int unsigned k;
      int unsigned n;
      logic [imzp_pkg::ACC_W-1:0] acc;
      product_type res;
      m = dim_in_use(rows_cfg, DIM_MAX);
      k = dim_in_use(inner_cfg, DIM_MAX);
      n = dim_in_use(cols_cfg, DIM_MAX);
      for (int unsigned r = 0; r < m; r++) begin
         for (int unsigned c = 0; c < n; c++) begin
            acc = '0;
            for (int unsigned i = 0; i < k; i++)
               acc = acc + 32'(elem_value(a_bytes[r*k+i], a_signed_cfg, a_zero_cfg)
                               * elem_value(b_bytes[i*n+c], b_signed_cfg, b_zero_cfg));
            res.value = acc;
            res.row   = 3'(r);
            res.col   = 3'(c);
            res.last  = (r + 1 == m) && (c + 1 == n);
            expected_products.push_back(res);
         end
      end
   endtask

   task automatic take_element(logic op, logic [imzp_pkg::ELEM_W-1:0] elem);
      int unsigned m;
      int unsigned k;
      int unsigned n;
      m = dim_in_use(rows_cfg, DIM_MAX);
      k = dim_in_use(inner_cfg, DIM_MAX);
      n = dim_in_use(cols_cfg, DIM_MAX);
      if (op == OP_LOAD_A) begin
         // drop A beats once the matrix is full
         if (a_fill < m * k) begin
            a_bytes[a_fill] = elem;
            a_fill++;
         end
      end else if (b_fill < k * n) begin
         b_bytes[b_fill] = elem;
         b_fill++;
         if (b_fill == k * n) begin
            multiply_matrices();
            a_fill = 0;
            b_fill = 0;
         end
      end
   endtask

   task automatic apply_register(imzp_pkg::csr_index_type idx,
                                 logic [imzp_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         imzp_pkg::CSR_ROWS_A:      rows_cfg     = data[3:0];
         imzp_pkg::CSR_INNER_LEN:   inner_cfg    = data[3:0];
         imzp_pkg::CSR_COLS_B:      cols_cfg     = data[3:0];
         imzp_pkg::CSR_A_IS_SIGNED: a_signed_cfg = data[0];
         imzp_pkg::CSR_B_IS_SIGNED: b_signed_cfg = data[0];
         imzp_pkg::CSR_A_OFFSET:    a_zero_cfg   = data;
         imzp_pkg::CSR_B_OFFSET:    b_zero_cfg   = data;
         default: ;
      endcase
      // any shape write restarts loading
      if (idx == imzp_pkg::CSR_ROWS_A || idx == imzp_pkg::CSR_INNER_LEN
          || idx == imzp_pkg::CSR_COLS_B) begin
         a_fill = 0;
         b_fill = 0;
      end
   endtask

   // ---------------- stimulus plan ----------------
   work_type    work_q[$];
   logic [3:0]  plan_rows  = 4'd8;
   logic [3:0]  plan_inner = 4'd8;
   logic [3:0]  plan_cols  = 4'd8;
   int unsigned plan_a_fill   = 0;
   int unsigned plan_b_fill   = 0;
   int unsigned plan_a_hi     = 0;  // A entries written at least once, always a prefix
   int unsigned planned_beats = 0;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (cycle_count[9:8] == 2'b11) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [imzp_pkg::ELEM_W-1:0] rand_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int unsigned pick_dim();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return 0;
      if (r == 1) return $urandom_range(9, 15);
      if (r < 4) return 8;
      return $urandom_range(1, 4);
   endfunction

   function automatic int unsigned pick_offset();
      case ($urandom_range(0, 7))
         0: return 9'h180;
         1: return 9'h0FF;
         2: return 0;
         3: return $urandom_range(0, 511);
         default: return ($urandom_range(0, 383) - 128) & 9'h1FF;
      endcase
   endfunction

   task automatic plan_register(imzp_pkg::csr_index_type idx, int unsigned value);
      work_type w;
      logic [imzp_pkg::CSR_DATA_W-1:0] junk;
      // unused upper bits must be ignored
      junk = ($urandom_range(0, 2) == 0) ? 9'($urandom_range(0, 511)) : '0;
      w.kind    = WORK_CSR;
      w.op      = OP_LOAD_A;
      w.elem    = '0;
      w.csr_idx = idx;
      case (idx)
         imzp_pkg::CSR_ROWS_A, imzp_pkg::CSR_INNER_LEN, imzp_pkg::CSR_COLS_B:
            w.csr_data = {junk[8:4], value[3:0]};
         imzp_pkg::CSR_A_IS_SIGNED, imzp_pkg::CSR_B_IS_SIGNED:
            w.csr_data = {junk[8:1], value[0]};
         default:
            w.csr_data = value[8:0];
      endcase
      case (idx)
         imzp_pkg::CSR_ROWS_A:    plan_rows  = value[3:0];
         imzp_pkg::CSR_INNER_LEN: plan_inner = value[3:0];
         imzp_pkg::CSR_COLS_B:    plan_cols  = value[3:0];
         default: ;
      endcase
      if (idx == imzp_pkg::CSR_ROWS_A || idx == imzp_pkg::CSR_INNER_LEN
          || idx == imzp_pkg::CSR_COLS_B) begin
         plan_a_fill = 0;
         plan_b_fill = 0;
      end
      work_q.push_back(w);
   endtask

   task automatic plan_element(logic op, logic [imzp_pkg::ELEM_W-1:0] elem);
      work_type w;
      int unsigned m;
      int unsigned k;
      int unsigned n;
      m = dim_in_use(plan_rows, DIM_MAX);
      k = dim_in_use(plan_inner, DIM_MAX);
      n = dim_in_use(plan_cols, DIM_MAX);
      w.kind     = WORK_BEAT;
      w.op       = op;
      w.elem     = elem;
      w.csr_idx  = imzp_pkg::CSR_ROWS_A;
      w.csr_data = '0;
      work_q.push_back(w);
      if (op == OP_LOAD_A) begin
         if (plan_a_fill < m * k) begin
            plan_a_fill++;
            planned_beats++;
            if (plan_a_fill > plan_a_hi) plan_a_hi = plan_a_fill;
         end
      end else if (plan_b_fill < k * n) begin
         plan_b_fill++;
         planned_beats++;
         if (plan_b_fill == k * n) begin
            plan_a_fill = 0;
            plan_b_fill = 0;
         end
      end
   endtask

   task automatic plan_pause();
      work_type w;
      w.kind     = WORK_PAUSE;
      w.op       = OP_LOAD_A;
      w.elem     = '0;
      w.csr_idx  = imzp_pkg::CSR_ROWS_A;
      w.csr_data = '0;
      work_q.push_back(w);
   endtask

   task automatic plan_quant_change();
      case ($urandom_range(0, 3))
         0: plan_register(imzp_pkg::CSR_A_IS_SIGNED, $urandom_range(0, 1));
         1: plan_register(imzp_pkg::CSR_B_IS_SIGNED, $urandom_range(0, 1));
         2: plan_register(imzp_pkg::CSR_A_OFFSET, pick_offset());
         default: plan_register(imzp_pkg::CSR_B_OFFSET, pick_offset());
      endcase
   endtask

   // One matrix from empty load counts, ending on the beat that completes B.
   task automatic plan_matrix();
      int unsigned a_need;
      int unsigned b_need;
      int unsigned a_left;
      int unsigned b_left;
      int unsigned mid_pos;
      int unsigned step;
      a_need = dim_in_use(plan_rows, DIM_MAX) * dim_in_use(plan_inner, DIM_MAX);
      b_need = dim_in_use(plan_inner, DIM_MAX) * dim_in_use(plan_cols, DIM_MAX);
      // finish B early only where every A entry in use holds a byte
      if (plan_a_hi >= a_need && $urandom_range(0, 5) == 0)
         a_left = $urandom_range(0, a_need - 1);
      else if ($urandom_range(0, 5) == 0)
         a_left = a_need + $urandom_range(1, 3);
      else
         a_left = a_need;
      b_left  = b_need;
      mid_pos = ($urandom_range(0, 7) == 0) ? $urandom_range(1, a_left + b_left) : 0;
      step    = 0;
      while (a_left + b_left > 0) begin
         step++;
         if (step == mid_pos) plan_quant_change();
         if (a_left > 0 && (b_left == 1 || $urandom_range(0, a_left + b_left - 1) < a_left)) begin
            plan_element(OP_LOAD_A, rand_byte());
            a_left--;
         end else begin
            plan_element(OP_LOAD_B, rand_byte());
            b_left--;
         end
      end
   endtask

   // Partial load abandoned by a shape rewrite.
   task automatic plan_restart();
      int unsigned na;
      int unsigned nb;
      na = $urandom_range(0, dim_in_use(plan_rows, DIM_MAX) * dim_in_use(plan_inner, DIM_MAX));
      nb = $urandom_range(0, dim_in_use(plan_inner, DIM_MAX) * dim_in_use(plan_cols, DIM_MAX) - 1);
      while (na + nb > 0) begin
         if (na > 0 && (nb == 0 || $urandom_range(0, 1))) begin
            plan_element(OP_LOAD_A, rand_byte());
            na--;
         end else begin
            plan_element(OP_LOAD_B, rand_byte());
            nb--;
         end
      end
      case ($urandom_range(0, 2))
         0: plan_register(imzp_pkg::CSR_ROWS_A, plan_rows);
         1: plan_register(imzp_pkg::CSR_INNER_LEN, plan_inner);
         default: plan_register(imzp_pkg::CSR_COLS_B, plan_cols);
      endcase
   endtask

   // ---------------- error reporting ----------------
   task automatic report_error(string msg);
      err_count++;
      if (err_count <= ERROR_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(string name, logic [imzp_pkg::ACC_W-1:0] got,
                              logic [imzp_pkg::ACC_W-1:0] want_v, product_type want);
      if (got !== want_v)
         report_error($sformatf("result (%0d,%0d) %s: got %0d expected %0d", want.row, want.col,
                                name, $signed(got), $signed(want_v)));
   endtask

   // ---------------- request driver ----------------
   int unsigned req_gap      = 0;
   int unsigned settle_count = 0;

   always @(posedge clock) begin
      logic                            hold;
      logic                            nxt_valid;
      logic                            nxt_op;
      logic [imzp_pkg::ELEM_W-1:0]     nxt_elem;
      logic                            nxt_wr;
      logic [imzp_pkg::CSR_ADDR_W-1:0] nxt_addr;
      logic [imzp_pkg::CSR_DATA_W-1:0] nxt_data;
      logic                            settled;
      work_type                        w;
      hold      = req_bus.valid && !req_bus.ready;
      nxt_valid = hold;
      nxt_op    = req_bus.op;
      nxt_elem  = req_bus.elem_byte;
      nxt_wr    = 1'b0;
      nxt_addr  = csr_addr;
      nxt_data  = csr_wr_data;
      if (reset) begin
         nxt_valid    = 1'b0;
         settle_count = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) take_element(req_bus.op, req_bus.elem_byte);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_wr_en)
            settle_count = 0;
         else if (settle_count < SETTLE_CYCLES)
            settle_count++;
         settled = (expected_products.size() == 0) && (settle_count >= SETTLE_CYCLES);
         if (!hold) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (work_q.size() > 0) begin
               w = work_q[0];
               case (w.kind)
                  WORK_BEAT: begin
                     nxt_valid = 1'b1;
                     nxt_op    = w.op;
                     nxt_elem  = w.elem;
                     void'(work_q.pop_front());
                     req_gap = pick_gap();
                  end
                  WORK_CSR: if (settled) begin
                     nxt_wr   = 1'b1;
                     nxt_addr = w.csr_idx;
                     nxt_data = w.csr_data;
                     apply_register(w.csr_idx, w.csr_data);
                     void'(work_q.pop_front());
                  end
                  default: if (settled) void'(work_q.pop_front());
               endcase
            end
         end
      end
      req_bus.valid     <= nxt_valid;
      req_bus.op        <= nxt_op;
      req_bus.elem_byte <= nxt_elem;
      csr_wr_en         <= nxt_wr;
      csr_addr          <= nxt_addr;
      csr_wr_data       <= nxt_data;
   end

   // ---------------- result monitor ----------------
   int unsigned rsp_stall = 0;

   always @(posedge clock) begin
      logic        nxt_ready;
      product_type want;
      if (reset) begin
         nxt_ready = 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_products.size() == 0) begin
               report_error($sformatf("unexpected result (%0d,%0d) value %0d", rsp_bus.out_row,
                                      rsp_bus.out_col, rsp_bus.product_value));
            end else begin
               want = expected_products.pop_front();
               check_field("product_value", rsp_bus.product_value, want.value, want);
               check_field("out_row", imzp_pkg::ACC_W'(rsp_bus.out_row),
                           imzp_pkg::ACC_W'(want.row), want);
               check_field("out_col", imzp_pkg::ACC_W'(rsp_bus.out_col),
                           imzp_pkg::ACC_W'(want.col), want);
               check_field("is_last", imzp_pkg::ACC_W'(rsp_bus.is_last),
                           imzp_pkg::ACC_W'(want.last), want);
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            nxt_ready = 1'b0;
         end else begin
            nxt_ready = 1'b1;
            rsp_stall = pick_gap();
         end
      end
      rsp_bus.ready <= nxt_ready;
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------- sequence ----------------
   initial begin
      req_bus.valid     = 1'b0;
      req_bus.op        = OP_LOAD_A;
      req_bus.elem_byte = '0;
      rsp_bus.ready     = 1'b0;

      // 1x1x1 with a zero row count, unsigned extremes
      plan_register(imzp_pkg::CSR_ROWS_A, 0);
      plan_register(imzp_pkg::CSR_INNER_LEN, 1);
      plan_register(imzp_pkg::CSR_COLS_B, 1);
      plan_element(OP_LOAD_A, 8'hFF);
      plan_element(OP_LOAD_B, 8'hFF);
      // signed bytes against extreme zero points
      plan_register(imzp_pkg::CSR_A_IS_SIGNED, 1);
      plan_register(imzp_pkg::CSR_B_IS_SIGNED, 1);
      plan_register(imzp_pkg::CSR_A_OFFSET, 9'h180);
      plan_register(imzp_pkg::CSR_B_OFFSET, 9'h0FF);
      plan_element(OP_LOAD_A, 8'h80);
      plan_element(OP_LOAD_B, 8'h7F);
      plan_element(OP_LOAD_A, 8'h7F);
      plan_element(OP_LOAD_B, 8'h80);
      plan_register(imzp_pkg::CSR_A_OFFSET, 9'h0FF);
      plan_register(imzp_pkg::CSR_B_OFFSET, 9'h180);
      plan_register(imzp_pkg::CSR_A_IS_SIGNED, 0);
      plan_register(imzp_pkg::CSR_B_IS_SIGNED, 0);
      plan_element(OP_LOAD_A, 8'h00);
      plan_element(OP_LOAD_B, 8'hFF);
      // row count above the maximum; one surplus A beat is dropped
      plan_register(imzp_pkg::CSR_ROWS_A, 15);
      for (int i = 0; i < 8; i++) plan_element(OP_LOAD_A, rand_byte());
      plan_element(OP_LOAD_A, 8'h55);
      plan_element(OP_LOAD_B, rand_byte());
      // B completes with only part of A reloaded
      plan_element(OP_LOAD_A, rand_byte());
      plan_element(OP_LOAD_A, rand_byte());
      plan_element(OP_LOAD_B, rand_byte());
      // shape rewrite in the middle of a load
      plan_register(imzp_pkg::CSR_ROWS_A, 1);
      plan_register(imzp_pkg::CSR_INNER_LEN, 2);
      plan_element(OP_LOAD_A, rand_byte());
      plan_element(OP_LOAD_B, rand_byte());
      plan_register(imzp_pkg::CSR_INNER_LEN, 2);
      plan_element(OP_LOAD_A, rand_byte());
      plan_element(OP_LOAD_A, rand_byte());
      plan_element(OP_LOAD_B, rand_byte());
      plan_element(OP_LOAD_B, rand_byte());
      // zero point changed while loading
      plan_element(OP_LOAD_A, rand_byte());
      plan_register(imzp_pkg::CSR_B_OFFSET, 9'h100);
      plan_element(OP_LOAD_A, rand_byte());
      plan_element(OP_LOAD_B, rand_byte());
      plan_element(OP_LOAD_B, rand_byte());
      plan_pause();

      while (planned_beats < BEAT_TARGET) begin
         if ($urandom_range(0, 9) == 0) plan_pause();
         if ($urandom_range(0, 2) == 0) begin
            plan_register(imzp_pkg::CSR_ROWS_A, pick_dim());
            plan_register(imzp_pkg::CSR_INNER_LEN, pick_dim());
            plan_register(imzp_pkg::CSR_COLS_B, pick_dim());
         end
         repeat ($urandom_range(0, 2)) plan_quant_change();
         if ($urandom_range(0, 9) == 0) plan_restart();
         plan_matrix();
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (work_q.size() != 0 || req_bus.valid || expected_products.size() != 0);
      repeat (END_CYCLES) @(posedge clock);

      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
